[rtl/core/kmp_pkg.sv]
`default_nettype none

package kmp_pkg;

	localparam int CAPACITY  = 256;
	localparam int CMD_W     = 2;
	localparam int OPERAND_W = 40;
	localparam int ANSWER_W  = 41;
	localparam int STATUS_W  = 2;

	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_DUP  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

	// Token that walks the cell chain, one cell per cycle.
	typedef struct packed {
		logic                 valid;
		logic                 query;  // 1: rank query, 0: insert
		logic                 probe;  // insert into a full table: look, never write
		logic                 carry;  // insert still holds a value to place
		logic                 dup;    // insert met an equal stored value
		logic [OPERAND_W-1:0] value;  // value being placed or pushed along
		logic [ANSWER_W-1:0]  thr;    // query: k + index + 1 at this cell
		logic [ANSWER_W-1:0]  acc;    // query: running answer
	} tok_t;

endpackage

`default_nettype wire

[rtl/core/kmp_cell.sv]
`default_nettype none

module kmp_cell (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          clear,
	input  wire kmp_pkg::tok_t tin,
	output kmp_pkg::tok_t      tout,
	output logic               occ
);

	logic                          occ_q;
	logic [kmp_pkg::OPERAND_W-1:0] val_q;
	kmp_pkg::tok_t                 tok_q;
	kmp_pkg::tok_t                 tok_d;
	logic                          wr_en;
	logic [kmp_pkg::OPERAND_W-1:0] wr_val;
	logic                          hit;

	assign hit = occ_q && ({1'b0, val_q} < tin.thr);

	always_comb begin
		tok_d  = tin;
		wr_en  = 1'b0;
		wr_val = tin.value;
		if (tin.valid) begin
			if (tin.query) begin
				tok_d.acc = tin.acc + {{(kmp_pkg::ANSWER_W-1){1'b0}}, hit};
				tok_d.thr = tin.thr + {{(kmp_pkg::ANSWER_W-1){1'b0}}, 1'b1};
			end else if (tin.carry) begin
				priority if (!occ_q) begin
					// first free cell: place the value here
					wr_en       = !tin.probe;
					tok_d.carry = 1'b0;
				end else if (val_q == tin.value) begin
					tok_d.dup   = 1'b1;
					tok_d.carry = 1'b0;
				end else if (val_q > tin.value) begin
					// take the value, push the stored one along
					wr_en       = !tin.probe;
					tok_d.value = val_q;
					tok_d.carry = !tin.probe;
				end else begin
					tok_d.carry = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
			if (clear) begin
				occ_q <= 1'b0;
			end else if (wr_en) begin
				occ_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			val_q <= wr_val;
		end
	end

	assign tout = tok_q;
	assign occ  = occ_q;

endmodule

`default_nettype wire

[rtl/core/kth_missing_positive_unit.sv]
`default_nettype none

// Sorted set of distinct positive integers answering k-th missing positive queries.
// Input channel: in_valid/in_ready carry command (clear, insert, query) and operand.
// Output channel: out_valid/out_ready carry answer and status, one result per command.
// Storage is a chain of CAPACITY identical cells, each holding one sorted value and
// its occupied flag. Insert and query launch a token that moves one cell per cycle:
// an insert finds its slot and shifts larger values up, a query counts the values
// below k + index + 1. The result is registered once the token has passed the launch
// register and every cell, so the chain length sets how long one insert or query takes.
// Clear, insert of zero and the unused code answer in the next cycle.
// One command is in flight at a time: in_ready drops while a token walks the chain
// and while a finished result waits in the output register with out_ready low.
// A stalled receiver holds the result in place; nothing is lost.
// Reset empties the set (all occupied flags clear) and drops any pending result.
module kth_missing_positive_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [kmp_pkg::CMD_W-1:0]     command,
	input  wire logic [kmp_pkg::OPERAND_W-1:0] operand,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [kmp_pkg::ANSWER_W-1:0]       answer,
	output logic [kmp_pkg::STATUS_W-1:0]       status
);

	kmp_pkg::tok_t                 link [kmp_pkg::CAPACITY+1];
	logic [kmp_pkg::CAPACITY-1:0]  occ_vec;
	kmp_pkg::tok_t                 launch_q;
	logic                          busy_q;
	logic                          out_valid_q;
	logic [kmp_pkg::ANSWER_W-1:0]  answer_q;
	logic [kmp_pkg::STATUS_W-1:0]  status_q;
	logic                          accept;
	logic                          goes_chain;
	logic                          clear;
	logic                          done;
	kmp_pkg::tok_t                 fin;

	// Take a new command only when nothing is in flight and the output slot frees up.
	assign in_ready = !busy_q && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;

	// Insert of a nonzero value and query walk the chain; the rest answer at once.
	assign goes_chain = accept && (((command == kmp_pkg::CMD_INSERT) && (operand != '0))
		|| (command == kmp_pkg::CMD_QUERY));
	assign clear = accept && (command == kmp_pkg::CMD_CLEAR);

	assign fin  = link[kmp_pkg::CAPACITY];
	assign done = fin.valid;

	// Launch token: a full table turns the insert into a look-only probe so
	// that duplicates are still flagged ahead of the full status.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			launch_q    <= '0;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			launch_q.valid <= goes_chain;
			if (accept) begin
				launch_q.query <= (command == kmp_pkg::CMD_QUERY);
				launch_q.probe <= occ_vec[kmp_pkg::CAPACITY-1];
				launch_q.carry <= 1'b1;
				launch_q.dup   <= 1'b0;
				launch_q.value <= operand;
				launch_q.thr   <= {1'b0, operand} + {{(kmp_pkg::ANSWER_W-1){1'b0}}, 1'b1};
				launch_q.acc   <= {1'b0, operand};
			end
			if (goes_chain) begin
				busy_q <= 1'b1;
			end else if (done) begin
				busy_q <= 1'b0;
			end
			if (done || (accept && !goes_chain)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Capture the result from the chain end or from an immediate command.
	always_ff @(posedge clk) begin
		if (done) begin
			if (fin.query) begin
				answer_q <= fin.acc;
				status_q <= kmp_pkg::STATUS_OK;
			end else begin
				answer_q <= '0;
				priority if (fin.dup) begin
					status_q <= kmp_pkg::STATUS_DUP;
				end else if (fin.probe) begin
					status_q <= kmp_pkg::STATUS_FULL;
				end else begin
					status_q <= kmp_pkg::STATUS_OK;
				end
			end
		end else if (accept && !goes_chain) begin
			answer_q <= '0;
			status_q <= kmp_pkg::STATUS_OK;
		end
	end

	assign link[0] = launch_q;

	for (genvar i = 0; i < kmp_pkg::CAPACITY; i++) begin : g_cell
		kmp_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.clear  (clear),
			.tin    (link[i]),
			.tout   (link[i+1]),
			.occ    (occ_vec[i])
		);
	end

	assign out_valid = out_valid_q;
	assign answer    = answer_q;
	assign status    = status_q;

	// A token leaves the chain only while a command is in flight.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy_q)
		else $error("token left the chain with no command in flight");

	// The output register is always free when the chain delivers.
	a_done_slot: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !out_valid_q)
		else $error("chain result would overwrite a pending result");

	// Occupied cells form a contiguous run from cell zero.
	a_occ_run: assert property (@(posedge clk) disable iff (!arst_n)
		(occ_vec & ~{occ_vec[kmp_pkg::CAPACITY-2:0], 1'b1}) == '0)
		else $error("occupied cells are not contiguous");

	// No new command is taken while a token walks the chain.
	a_one_flight: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !in_ready)
		else $error("input accepted while a command is in flight");

endmodule

`default_nettype wire

[test/kth_missing_positive_unit_tb.sv]
`timescale 1ns / 1ps

module kth_missing_positive_unit_tb;

	import kmp_pkg::*;

	localparam time CLK_PERIOD    = 8ns;
	localparam int  RESET_CYCLES  = 6;
	// A walk down the chain passes the launch register and every cell; leave margin on top.
	localparam int  DRAIN_CYCLES  = CAPACITY + 40;
	localparam int  LONG_HOLD     = 2000;
	localparam time RUN_LIMIT     = 8ms;

	// The fourth command code is unused by the block and must act as a no-op.
	localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

	localparam logic [OPERAND_W-1:0] OPERAND_MAX = {OPERAND_W{1'b1}};

	typedef struct packed {
		logic [ANSWER_W-1:0] answer;
		logic [STATUS_W-1:0] status;
	} result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [CMD_W-1:0]     command;
	logic [OPERAND_W-1:0] operand;
	logic                 out_valid;
	logic                 out_ready;
	logic [ANSWER_W-1:0]  answer;
	logic [STATUS_W-1:0]  status;

	// Own copy of the table: ascending, distinct, positive.
	logic [OPERAND_W-1:0] model_set[$];
	result_t              pending_results[$];

	bit idle_on;       // random bursts of idling on both channels
	bit long_hold;     // ask the receiver for one long hold-off

	int error_count;
	int sent_count;
	int result_count;
	int insert_count;
	int dup_count;
	int full_count;
	int query_count;
	int clear_count;

	kth_missing_positive_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.operand   (operand),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.answer    (answer),
		.status    (status)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Hard stop in case a handshake never completes.
	initial begin
		#(RUN_LIMIT);
		$display("timeout: %0d results still pending at %0t", pending_results.size(), $time);
		$display("end of test: mismatches");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		error_count++;
		$display("ERROR %0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
	endtask

	function automatic logic [OPERAND_W-1:0] wide_value();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[OPERAND_W-1:0];
	endfunction

	function automatic bit value_stored(input logic [OPERAND_W-1:0] v);
		foreach (model_set[i])
			if (model_set[i] == v)
				return 1'b1;
		return 1'b0;
	endfunction

	// Apply one command to the table copy and work out the result it must give.
	function automatic result_t predict_result(input logic [CMD_W-1:0] cmd,
			input logic [OPERAND_W-1:0] opnd);
		result_t             r;
		int                  pos;
		logic [ANSWER_W-1:0] gap;
		r.answer = '0;
		r.status = STATUS_OK;
		case (cmd)
			CMD_CLEAR: begin
				model_set.delete();
				clear_count++;
			end
			CMD_INSERT: begin
				// zero is not positive: ignore it, report ok
				if (opnd != '0) begin
					insert_count++;
					pos = 0;
					while (pos < model_set.size() && model_set[pos] < opnd)
						pos++;
					if (pos < model_set.size() && model_set[pos] == opnd) begin
						// duplicate wins over full
						r.status = STATUS_DUP;
						dup_count++;
					end else if (model_set.size() >= CAPACITY) begin
						r.status = STATUS_FULL;
						full_count++;
					end else begin
						model_set.insert(pos, opnd);
					end
				end
			end
			CMD_QUERY: begin
				query_count++;
				r.answer = {1'b0, opnd};
				foreach (model_set[i]) begin
					gap = {1'b0, model_set[i]} - ANSWER_W'(i) - ANSWER_W'(1);
					if (gap < {1'b0, opnd})
						r.answer = r.answer + 1'b1;
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// Offer one item and hold it until the transfer. Valid stays high after
	// the transfer so that a following item can go out on the very next edge;
	// stop_sending lowers it when the sender pauses for good.
	task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [OPERAND_W-1:0] opnd);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command  <= cmd;
		operand  <= opnd;
		do
			@(posedge clk);
		while (!in_ready);
		sent_count++;
		pending_results.push_back(predict_result(cmd, opnd));
	endtask

	// Drop valid, then let every expected result arrive and the chain settle.
	task automatic stop_sending();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Receiver side: random hold-offs, plus one long hold on request.
	initial begin : sink_ready
		int n;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				out_ready <= 1'b0;
				for (n = 0; n < LONG_HOLD; n++)
					@(posedge clk);
				long_hold = 1'b0;
				out_ready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Compare every transfer on the result channel with the oldest expectation.
	initial begin : result_check
		result_t want;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				result_count++;
				if (pending_results.size() == 0) begin
					report_mismatch("result with nothing pending", {answer, status}, '0);
				end else begin
					want = pending_results.pop_front();
					if (answer !== want.answer)
						report_mismatch("answer", answer, want.answer);
					if (status !== want.status)
						report_mismatch("status", status, want.status);
				end
			end
		end
	end

	// Extremes of both fields, every command code and each corner case.
	task automatic test_directed();
		send_item(CMD_QUERY, 40'd1);          // empty set answers k
		send_item(CMD_QUERY, 40'd0);          // rank zero
		send_item(CMD_QUERY, OPERAND_MAX);
		send_item(CMD_INSERT, 40'd0);         // zero is ignored
		send_item(CMD_INSERT, 40'd1);
		send_item(CMD_INSERT, 40'd3);
		send_item(CMD_INSERT, OPERAND_MAX);
		send_item(CMD_INSERT, 40'd3);         // duplicate
		send_item(CMD_QUERY, 40'd1);
		send_item(CMD_QUERY, 40'd2);
		send_item(CMD_QUERY, OPERAND_MAX);    // answer needs the top bit
		send_item(CMD_QUERY, 40'd0);
		send_item(CMD_NOP, OPERAND_MAX);
		send_item(CMD_INSERT, 40'd2);
		send_item(CMD_QUERY, 40'd1);
		send_item(CMD_CLEAR, OPERAND_MAX);
		send_item(CMD_QUERY, 40'd5);
		send_item(CMD_INSERT, OPERAND_MAX);   // allowed again after clear
		send_item(CMD_QUERY, OPERAND_MAX);
		send_item(CMD_NOP, 40'd0);
		send_item(CMD_INSERT, wide_value());
		send_item(CMD_QUERY, wide_value());
		stop_sending();
	endtask

	// Fill every cell, hit the full table with duplicate, new and zero inserts, then query it.
	task automatic test_full_table();
		logic [OPERAND_W-1:0] v;
		int                   i;
		send_item(CMD_CLEAR, wide_value());
		while (model_set.size() < CAPACITY) begin
			v = $urandom_range(0, 1) ? OPERAND_W'($urandom_range(1, 400)) : wide_value();
			send_item(CMD_INSERT, v);
		end
		send_item(CMD_INSERT, model_set[0]);                 // duplicate into full table
		send_item(CMD_INSERT, model_set[CAPACITY - 1]);
		do
			v = wide_value();
		while (v == '0 || value_stored(v));
		send_item(CMD_INSERT, v);                            // table full
		send_item(CMD_INSERT, 40'd0);
		send_item(CMD_QUERY, 40'd0);
		send_item(CMD_QUERY, 40'd1);
		send_item(CMD_QUERY, OPERAND_MAX);
		for (i = 0; i < 6; i++)
			send_item(CMD_QUERY, $urandom_range(0, 1) ? OPERAND_W'($urandom_range(1, 700))
				: wide_value());
		send_item(CMD_CLEAR, 40'd0);
		stop_sending();
	endtask

	// Hold the receiver off long enough that the block stops taking commands.
	task automatic test_backpressure();
		int i;
		long_hold = 1'b1;
		for (i = 0; i < 8; i++)
			send_item($urandom_range(0, 1) ? CMD_INSERT : CMD_QUERY,
				OPERAND_W'($urandom_range(1, 20)));
		stop_sending();
	endtask

	function automatic logic [OPERAND_W-1:0] pick_value(input int style, input int n);
		case (style)
			0:       return OPERAND_W'($urandom_range(1, 2 * n + 2));
			1:       return wide_value();
			2:       return OPERAND_MAX - OPERAND_W'($urandom_range(0, 2 * n));
			default: return $urandom_range(0, 1) ? OPERAND_W'($urandom_range(1, 3 * n))
				: wide_value();
		endcase
	endfunction

	function automatic logic [OPERAND_W-1:0] pick_rank(input int style, input int n);
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return OPERAND_MAX;
			2:       return wide_value();
			default: begin
				if (style == 2 && $urandom_range(0, 1))
					return OPERAND_MAX - OPERAND_W'($urandom_range(0, 3 * n + 4));
				return OPERAND_W'($urandom_range(1, 3 * n + 4));
			end
		endcase
	endfunction

	// Episodes of clear, a burst of inserts with queries mixed in, then queries.
	// Noise items (unused code, insert of zero or of a wide value) are not counted.
	task automatic test_random_mix(input int target);
		int sent;
		int n_ins;
		int style;
		int i;
		sent = 0;
		while (sent < target) begin
			style = $urandom_range(0, 3);
			n_ins = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 30);
			send_item(CMD_CLEAR, wide_value());
			sent++;
			for (i = 0; i < n_ins && sent < target; i++) begin
				send_item(CMD_INSERT, pick_value(style, n_ins));
				sent++;
				if ($urandom_range(0, 3) == 0) begin
					send_item(CMD_QUERY, pick_rank(style, n_ins));
					sent++;
				end
				if ($urandom_range(0, 19) == 0)
					send_item($urandom_range(0, 1) ? CMD_NOP : CMD_INSERT,
						$urandom_range(0, 1) ? wide_value() : '0);
			end
			repeat ($urandom_range(1, 6)) begin
				send_item(CMD_QUERY, pick_rank(style, n_ins));
				sent++;
			end
		end
		stop_sending();
	endtask

	initial begin : main
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		command     <= CMD_CLEAR;
		operand     <= '0;
		idle_on     = 1'b1;
		long_hold   = 1'b0;
		error_count = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_directed();
		test_full_table();
		test_backpressure();
		test_random_mix(440);
		// Last stretch with both sides at full rate.
		idle_on = 1'b0;
		test_random_mix(60);

		while (pending_results.size() != 0) begin
			report_mismatch("result never arrived", '0, pending_results.pop_front());
		end
		$display("run covered %0d commands, %0d results: %0d inserts (%0d duplicate, %0d full)",
			sent_count, result_count, insert_count, dup_count, full_count);
		$display("  %0d queries, %0d clears, a full table and a long receiver hold-off",
			query_count, clear_count);
		if (error_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
